FILE: src/rpn_pkg.sv
// Package for the RPN stack calculator: sizes, command, operator and status codes.
// Depends on nothing; used by every file in src.
package rpn_pkg;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned DepthW     = 5;
  localparam int unsigned QuotW      = DataW + FracBits + 1;

  typedef enum logic [1:0] {CmdPush = 2'd0, CmdOp = 2'd1, CmdClear = 2'd2, CmdNone = 2'd3} cmd_e;
  typedef enum logic [1:0] {OpAdd = 2'd0, OpSub = 2'd1, OpMul = 2'd2, OpDiv = 2'd3} op_e;
  typedef enum logic [1:0] {StOk = 2'd0, StUnder = 2'd1, StOver = 2'd2, StDivZero = 2'd3} status_e;

  // Control that the top level sends to every stack cell.
  typedef struct packed {
    logic push;   // shift down: each cell takes its upper neighbor, top takes new value
    logic pop;    // shift up: each cell takes its lower neighbor
    logic wr_top; // top cell loads the new value (with push or pop)
  } cell_ctl_t;
endpackage

FILE: src/rpn_cell.sv
// One stack cell: holds one entry and passes it to a neighbor on push or pop.
// Depends on rpn_pkg.
module rpn_cell (
  input  logic                      clk_i,
  input  rpn_pkg::cell_ctl_t        ctl_i,
  input  logic                      is_top_i,
  input  logic [rpn_pkg::DataW-1:0] top_val_i,
  input  logic [rpn_pkg::DataW-1:0] upper_i,
  input  logic [rpn_pkg::DataW-1:0] lower_i,
  output logic [rpn_pkg::DataW-1:0] data_o
);
  logic [rpn_pkg::DataW-1:0] data_q, data_d;
  always_comb begin
    data_d = data_q;
    if (is_top_i && ctl_i.wr_top) begin
      data_d = top_val_i;
    end else if (ctl_i.push) begin
      data_d = upper_i;
    end else if (ctl_i.pop) begin
      data_d = lower_i;
    end
  end
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end
  assign data_o = data_q;
endmodule

FILE: src/rpn_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on rpn_pkg.
module rpn_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rpn_pkg::QuotW-1:0] dividend_i,
  input  logic [rpn_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [rpn_pkg::QuotW-1:0] quot_o
);
  localparam int unsigned StepW = $clog2(rpn_pkg::QuotW + 1);
  logic [rpn_pkg::QuotW-1:0] quot_q, quot_d;
  logic [rpn_pkg::DataW-1:0] rem_q, rem_d;
  logic [rpn_pkg::DataW-1:0] dvs_q, dvs_d;
  logic [StepW-1:0]          cnt_q, cnt_d;
  logic                      run_q, run_d, done_q, done_d;
  logic [rpn_pkg::DataW:0]   trial;
  logic [rpn_pkg::DataW:0]   diff;

  always_comb begin
    quot_d = quot_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    run_d = run_q; done_d = 1'b0;
    trial = {rem_q, quot_q[rpn_pkg::QuotW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i; rem_d = '0; dvs_d = divisor_i;
      cnt_d = StepW'(rpn_pkg::QuotW); run_d = 1'b1;
    end else if (run_q) begin
      // The remainder stays below the divisor, so it always fits in DataW bits.
      if (!diff[rpn_pkg::DataW]) begin
        rem_d  = diff[rpn_pkg::DataW-1:0];
        quot_d = {quot_q[rpn_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_d  = trial[rpn_pkg::DataW-1:0];
        quot_d = {quot_q[rpn_pkg::QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

FILE: src/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: command sequencer, ALU and a row of stack cells.
// Depends on rpn_pkg, rpn_cell and rpn_divider.
//
// An item is taken when start_i is high and busy_o is low; exactly one result follows,
// shown for one cycle with valid_o high, and the receiver cannot stall it. The stack is a
// row of StackDepth cells that shift down on a push and up on a pop, so the top two
// entries sit in fixed cells and no addressed memory is needed. Push, clear, add and
// subtract go from SExec straight to SDone; multiply passes SMul after one registered
// 32x32 product stage, and divide waits in SDiv for the restoring divider that retires
// one quotient bit per cycle over 49 bits. busy_o drops in the cycle before the
// result is shown, so a new item can be accepted at the edge that starts the result cycle.
// Underflow, overflow and divide by zero leave the stack as it was.
module rpn_stack_calculator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                cmd_i,
  input  logic [1:0]                op_i,
  input  logic signed [31:0]        value_i,
  output logic                      valid_o,
  output logic signed [31:0]        result_o,
  output logic [1:0]                status_o,
  output logic [4:0]                depth_o
);
  localparam int unsigned DW = rpn_pkg::DataW;
  localparam logic [2:0] SIdle = 3'd0, SExec = 3'd1, SMul = 3'd2, SDiv = 3'd3, SDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic [rpn_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [1:0] cmd_q, op_q;
  logic [DW-1:0] val_q;
  logic [DW-1:0] res_q, res_d;
  logic [1:0]    st_q, st_d;
  logic          valid_q, valid_d;
  logic          neg_q, neg_d;
  logic [2*DW-1:0] prod_q;
  rpn_pkg::cell_ctl_t ctl;
  logic [DW-1:0] top_val;
  logic [DW-1:0] cell_data [rpn_pkg::StackDepth];
  logic          div_start, div_done;
  logic [rpn_pkg::QuotW-1:0] div_quot;

  // Top of stack is cell 0, next is cell 1.
  wire signed [DW-1:0] rhs = cell_data[0];
  wire signed [DW-1:0] lhs = cell_data[1];
  wire [DW-1:0] mag_l = lhs[DW-1] ? DW'(-lhs) : lhs;
  wire [DW-1:0] mag_r = rhs[DW-1] ? DW'(-rhs) : rhs;
  wire signed [DW:0] sum  = {lhs[DW-1], lhs} + {rhs[DW-1], rhs};
  wire signed [DW:0] diff = {lhs[DW-1], lhs} - {rhs[DW-1], rhs};

  function automatic logic [DW-1:0] sat33(input logic [DW:0] x);
    if (x[DW] != x[DW-1]) return x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    return x[DW-1:0];
  endfunction

  // Saturate a sign and magnitude pair; magnitude is given as a wide vector.
  function automatic logic [DW-1:0] satmag(input logic neg, input logic [2*DW-1:0] m);
    if (neg) begin
      if (m >= (2*DW)'(64'h8000_0000)) return {1'b1, {(DW-1){1'b0}}};
      return DW'(-m);
    end
    if (m > (2*DW)'(64'h7FFF_FFFF)) return {1'b0, {(DW-1){1'b1}}};
    return m[DW-1:0];
  endfunction

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; res_d = res_q; st_d = st_q;
    valid_d = 1'b0; neg_d = neg_q; ctl = '0; top_val = val_q; div_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start_i) state_d = SExec;
      end
      SExec: begin
        res_d = '0; st_d = rpn_pkg::StOk; neg_d = lhs[DW-1] ^ rhs[DW-1];
        state_d = SDone;
        case (cmd_q)
          rpn_pkg::CmdPush: begin
            if (cnt_q >= rpn_pkg::CntW'(rpn_pkg::StackDepth)) st_d = rpn_pkg::StOver;
            else begin
              ctl.push = 1'b1; ctl.wr_top = 1'b1; top_val = val_q;
              res_d = val_q; cnt_d = cnt_q + 1'b1;
            end
          end
          rpn_pkg::CmdOp: begin
            if (cnt_q < rpn_pkg::CntW'(2)) st_d = rpn_pkg::StUnder;
            else begin
              case (op_q) inside
                rpn_pkg::OpAdd, rpn_pkg::OpSub: begin
                  top_val = sat33(op_q == rpn_pkg::OpAdd ? sum : diff);
                  res_d = top_val; ctl.pop = 1'b1; ctl.wr_top = 1'b1;
                  cnt_d = cnt_q - 1'b1;
                end
                rpn_pkg::OpMul: state_d = SMul;
                default: begin
                  if (rhs == '0) st_d = rpn_pkg::StDivZero;
                  else begin
                    div_start = 1'b1; state_d = SDiv;
                  end
                end
              endcase
            end
          end
          rpn_pkg::CmdClear: cnt_d = '0;
          default: ;
        endcase
      end
      SMul: begin
        top_val = satmag(neg_q, prod_q >> rpn_pkg::FracBits);
        res_d = top_val; ctl.pop = 1'b1; ctl.wr_top = 1'b1;
        cnt_d = cnt_q - 1'b1; state_d = SDone;
      end
      SDiv: begin
        top_val = satmag(neg_q, (2*DW)'(div_quot));
        if (div_done) begin
          res_d = top_val; ctl.pop = 1'b1; ctl.wr_top = 1'b1;
          cnt_d = cnt_q - 1'b1; state_d = SDone;
        end
      end
      SDone: begin
        valid_d = 1'b1; state_d = start_i ? SExec : SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q <= cmd_i; op_q <= op_i; val_q <= value_i;
    end
    res_q <= res_d; st_q <= st_d; neg_q <= neg_d;
    prod_q <= mag_l * mag_r;
  end

  rpn_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({1'b0, mag_l, {rpn_pkg::FracBits{1'b0}}}),
    .divisor_i(mag_r), .done_o(div_done), .quot_o(div_quot)
  );

  for (genvar g = 0; g < rpn_pkg::StackDepth; g++) begin : g_cell
    rpn_cell u_cell (
      .clk_i, .ctl_i(ctl), .is_top_i(g == 0), .top_val_i(top_val),
      .upper_i(g == 0 ? top_val : cell_data[(g == 0) ? 0 : g - 1]),
      .lower_i(cell_data[(g == rpn_pkg::StackDepth - 1) ? g : g + 1]),
      .data_o(cell_data[g])
    );
  end

  assign busy_o   = (state_q != SIdle) && (state_q != SDone);
  assign valid_o  = valid_q;
  assign result_o = res_q;
  assign status_o = st_q;
  assign depth_o  = rpn_pkg::DepthW'(cnt_q);
endmodule

FILE: src/rpn_checker.sv
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_calculator.
module rpn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic [1:0] status_o,
  input logic [4:0] depth_o,
  input logic signed [31:0] result_o
);
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_o <= 5'(rpn_pkg::StackDepth)) else $error("depth beyond stack size");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != rpn_pkg::StOk |-> result_o == 0) else $error("error result not zero");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not raise busy");
  a_depth_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |=> $stable(depth_o)) else $error("depth moved while idle");
endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);
